// File: rtl/rsb_pkg.sv
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared types and codes for the prefixed rotate/shift/bit unit.
// ----------------------------------------------------------------------------
package rsb_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic [1:0] MODE_EXEC       = 2'd0;
	localparam logic [1:0] MODE_LOAD_REG   = 2'd1;
	localparam logic [1:0] MODE_LOAD_FLAGS = 2'd2;

	localparam logic [1:0] GRP_SHIFT = 2'd0;
	localparam logic [1:0] GRP_BIT   = 2'd1;
	localparam logic [1:0] GRP_RES   = 2'd2;
	localparam logic [1:0] GRP_SET   = 2'd3;

	localparam logic [2:0] SH_RLC  = 3'd0;
	localparam logic [2:0] SH_RRC  = 3'd1;
	localparam logic [2:0] SH_RL   = 3'd2;
	localparam logic [2:0] SH_RR   = 3'd3;
	localparam logic [2:0] SH_SLA  = 3'd4;
	localparam logic [2:0] SH_SRA  = 3'd5;
	localparam logic [2:0] SH_SWAP = 3'd6;
	localparam logic [2:0] SH_SRL  = 3'd7;

	localparam logic [2:0] OP_NOP        = 3'd0;
	localparam logic [2:0] OP_SHIFT      = 3'd1;
	localparam logic [2:0] OP_BIT        = 3'd2;
	localparam logic [2:0] OP_RES        = 3'd3;
	localparam logic [2:0] OP_SET        = 3'd4;
	localparam logic [2:0] OP_LOAD_REG   = 3'd5;
	localparam logic [2:0] OP_LOAD_FLAGS = 3'd6;

	localparam logic [2:0] MEM_INDEX = 3'd6;
	localparam logic [2:0] REG_H     = 3'd4;
	localparam logic [2:0] REG_L     = 3'd5;

	localparam logic [4:0] CYC_NONE    = 5'd0;
	localparam logic [4:0] CYC_REG     = 5'd8;
	localparam logic [4:0] CYC_BIT_MEM = 5'd12;
	localparam logic [4:0] CYC_MEM     = 5'd16;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] sel;
		logic [2:0] idx;
		logic       is_mem;
		logic       write_reg;
		logic       mem_write;
		logic [4:0] cycles;
		logic [7:0] operand;
	} uop_t;

endpackage

// File: rtl/rsb_front.sv
// ----------------------------------------------------------------------------
// rsb_front
// Accepts input items and decodes them into micro-ops for the queue.
// ----------------------------------------------------------------------------
module rsb_front (
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [1:0]   mode,
	input  logic [7:0]   opcode,
	input  logic [2:0]   target_reg,
	input  logic [7:0]   operand_byte,
	input  logic         q_full,
	output logic         push,
	output rsb_pkg::uop_t uop
);

	logic is_mem;
	logic writes;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign is_mem   = (opcode[2:0] == rsb_pkg::MEM_INDEX);
	assign writes   = (opcode[7:6] != rsb_pkg::GRP_BIT);

	always_comb begin
		uop         = '0;
		uop.operand = operand_byte;
		case (mode)
			rsb_pkg::MODE_EXEC: begin
				uop.idx       = opcode[2:0];
				uop.sel       = opcode[5:3];
				uop.is_mem    = is_mem;
				uop.write_reg = writes && !is_mem;
				uop.mem_write = writes && is_mem;
				if (!is_mem) begin
					uop.cycles = rsb_pkg::CYC_REG;
				end else if (writes) begin
					uop.cycles = rsb_pkg::CYC_MEM;
				end else begin
					uop.cycles = rsb_pkg::CYC_BIT_MEM;
				end
				case (opcode[7:6])
					rsb_pkg::GRP_SHIFT: uop.op = rsb_pkg::OP_SHIFT;
					rsb_pkg::GRP_BIT:   uop.op = rsb_pkg::OP_BIT;
					rsb_pkg::GRP_RES:   uop.op = rsb_pkg::OP_RES;
					default:            uop.op = rsb_pkg::OP_SET;
				endcase
			end
			rsb_pkg::MODE_LOAD_REG: begin
				uop.op        = rsb_pkg::OP_LOAD_REG;
				uop.idx       = target_reg;
				uop.write_reg = (target_reg != rsb_pkg::MEM_INDEX);
				uop.cycles    = rsb_pkg::CYC_NONE;
			end
			rsb_pkg::MODE_LOAD_FLAGS: begin
				uop.op     = rsb_pkg::OP_LOAD_FLAGS;
				uop.cycles = rsb_pkg::CYC_NONE;
			end
			default: begin
				uop.op = rsb_pkg::OP_NOP;
			end
		endcase
	end

endmodule

// File: rtl/rsb_queue.sv
// ----------------------------------------------------------------------------
// rsb_queue
// Short FIFO of decoded micro-ops between front and back.
// ----------------------------------------------------------------------------
module rsb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rsb_pkg::uop_t push_uop,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output rsb_pkg::uop_t head_uop
);

	rsb_pkg::uop_t                entry_q [rsb_pkg::QUEUE_DEPTH];
	logic [rsb_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [rsb_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [rsb_pkg::QCNT_W-1:0]   count_q;

	assign full       = (count_q == rsb_pkg::QCNT_W'(rsb_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_uop   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_uop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/rsb_back.sv
// ----------------------------------------------------------------------------
// rsb_back
// Executes micro-ops against the register file and flags; holds the result.
// ----------------------------------------------------------------------------
module rsb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  rsb_pkg::uop_t q_uop,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    result_byte,
	output logic          mem_write,
	output logic [15:0]   mem_addr,
	output logic          zero_flag,
	output logic          subtract_flag,
	output logic          half_flag,
	output logic          carry_flag,
	output logic [4:0]    cycle_count
);

	logic [7:0]  reg_q [8];
	logic [3:0]  flags_q;
	logic        out_valid_q;
	logic [7:0]  result_q;
	logic        mem_write_q;
	logic [15:0] mem_addr_q;
	logic [3:0]  out_flags_q;
	logic [4:0]  cycles_q;

	logic [7:0]  value;
	logic [7:0]  mask;
	logic        cin;
	logic [7:0]  sh_res;
	logic        sh_c;
	logic [7:0]  res;
	logic [3:0]  nflags;

	assign pop   = q_valid && (!out_valid_q || !out_stall);
	assign value = q_uop.is_mem ? q_uop.operand : reg_q[q_uop.idx];
	assign mask  = 8'b1 << q_uop.sel;
	assign cin   = flags_q[0];

	always_comb begin
		case (q_uop.sel)
			rsb_pkg::SH_RLC:  begin sh_c = value[7]; sh_res = {value[6:0], value[7]}; end
			rsb_pkg::SH_RRC:  begin sh_c = value[0]; sh_res = {value[0], value[7:1]}; end
			rsb_pkg::SH_RL:   begin sh_c = value[7]; sh_res = {value[6:0], cin}; end
			rsb_pkg::SH_RR:   begin sh_c = value[0]; sh_res = {cin, value[7:1]}; end
			rsb_pkg::SH_SLA:  begin sh_c = value[7]; sh_res = {value[6:0], 1'b0}; end
			rsb_pkg::SH_SRA:  begin sh_c = value[0]; sh_res = {value[7], value[7:1]}; end
			rsb_pkg::SH_SWAP: begin sh_c = 1'b0;     sh_res = {value[3:0], value[7:4]}; end
			default:          begin sh_c = value[0]; sh_res = {1'b0, value[7:1]}; end
		endcase
	end

	always_comb begin
		res    = 8'h00;
		nflags = flags_q;
		case (q_uop.op)
			rsb_pkg::OP_SHIFT: begin
				res    = sh_res;
				nflags = {sh_res == 8'h00, 1'b0, 1'b0, sh_c};
			end
			rsb_pkg::OP_BIT: begin
				res    = value;
				nflags = {(value & mask) == 8'h00, 1'b0, 1'b1, flags_q[0]};
			end
			rsb_pkg::OP_RES:       res = value & ~mask;
			rsb_pkg::OP_SET:       res = value | mask;
			rsb_pkg::OP_LOAD_REG:  res = q_uop.operand;
			rsb_pkg::OP_LOAD_FLAGS: begin
				res    = {q_uop.operand[7:4], 4'h0};
				nflags = q_uop.operand[7:4];
			end
			default: res = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				reg_q[i] <= 8'h00;
			end
			flags_q     <= 4'h0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				flags_q     <= nflags;
				out_valid_q <= 1'b1;
				if (q_uop.write_reg) begin
					reg_q[q_uop.idx] <= res;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q    <= res;
			mem_write_q <= q_uop.mem_write;
			mem_addr_q  <= {reg_q[rsb_pkg::REG_H], reg_q[rsb_pkg::REG_L]};
			out_flags_q <= nflags;
			cycles_q    <= q_uop.cycles;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_byte   = result_q;
	assign mem_write     = mem_write_q;
	assign mem_addr      = mem_addr_q;
	assign zero_flag     = out_flags_q[3];
	assign subtract_flag = out_flags_q[2];
	assign half_flag     = out_flags_q[1];
	assign carry_flag    = out_flags_q[0];
	assign cycle_count   = cycles_q;

endmodule

// File: rtl/prefixed_rotate_shift_bit_unit.sv
// ----------------------------------------------------------------------------
// prefixed_rotate_shift_bit_unit
// Prefixed-opcode rotate/shift/BIT/RES/SET unit with its own register file.
// ----------------------------------------------------------------------------
// One item is taken per clock and one result item leaves per clock when the
// output is not stalled. An accepted item is written into the four-entry
// decode queue and, once the output register is free or being emptied, is
// executed from the queue head into the output register, where its result
// stays valid until it leaves. The execute stage reads, updates and writes
// back the register file and flags in the same cycle, so dependent items
// follow back to back. The input stalls only when the queue is full, which
// takes a held output plus four queued items. A memory operand is supplied
// with the item; a changed memory byte comes back with mem_write set and the
// H:L address as it stood before the item.
// ----------------------------------------------------------------------------
module prefixed_rotate_shift_bit_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  opcode,
	input  logic [2:0]  target_reg,
	input  logic [7:0]  operand_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  result_byte,
	output logic        mem_write,
	output logic [15:0] mem_addr,
	output logic        zero_flag,
	output logic        subtract_flag,
	output logic        half_flag,
	output logic        carry_flag,
	output logic [4:0]  cycle_count
);

	rsb_pkg::uop_t push_uop;
	rsb_pkg::uop_t head_uop;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_valid;

	rsb_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.opcode       (opcode),
		.target_reg   (target_reg),
		.operand_byte (operand_byte),
		.q_full       (q_full),
		.push         (push),
		.uop          (push_uop)
	);

	rsb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_uop   (push_uop),
		.pop        (pop),
		.full       (q_full),
		.head_valid (q_valid),
		.head_uop   (head_uop)
	);

	rsb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_uop         (head_uop),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_byte   (result_byte),
		.mem_write     (mem_write),
		.mem_addr      (mem_addr),
		.zero_flag     (zero_flag),
		.subtract_flag (subtract_flag),
		.half_flag     (half_flag),
		.carry_flag    (carry_flag),
		.cycle_count   (cycle_count)
	);

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the prefixed rotate/shift/bit unit. A short table of
// directed items (loads, every shift kind, BIT/RES/SET on registers and on the
// memory operand, the unused mode) is followed by random items in blocks with
// changing idle patterns on both sides, one long output hold-off, and one
// drain pause. A shadow register file and flag set predict each result item
// not given in the table; all are compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [2:0] REG_B = 3'd0;
	localparam logic [2:0] REG_C = 3'd1;
	localparam logic [2:0] REG_D = 3'd2;
	localparam logic [2:0] REG_E = 3'd3;
	localparam logic [2:0] REG_A = 3'd7;
	localparam int RANDOM_BLOCKS = 33;
	localparam int BLOCK_ITEMS = 50;
	localparam int HOLD_CYCLES = 40;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] opcode;
		logic [2:0] tgt;
		logic [7:0] operand;
	} item_t;

	typedef struct packed {
		logic [7:0]  value;
		logic        mw;
		logic [15:0] addr;
		logic        z;
		logic        n;
		logic        h;
		logic        c;
		logic [4:0]  cycles;
	} res_t;

	typedef struct {
		item_t stim;
		bit    known;
		res_t  want;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [7:0]  opcode;
	logic [2:0]  target_reg;
	logic [7:0]  operand_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  result_byte;
	logic        mem_write;
	logic [15:0] mem_addr;
	logic        zero_flag;
	logic        subtract_flag;
	logic        half_flag;
	logic        carry_flag;
	logic [4:0]  cycle_count;

	logic [7:0] shadow_regs [8];
	logic [3:0] shadow_flags;
	res_t       pending_results [$];
	row_t       directed [$];
	int         mismatches;
	bit         send_idle;
	bit         recv_idle;
	bit         hold_req;

	prefixed_rotate_shift_bit_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.opcode       (opcode),
		.target_reg   (target_reg),
		.operand_byte (operand_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_byte  (result_byte),
		.mem_write    (mem_write),
		.mem_addr     (mem_addr),
		.zero_flag    (zero_flag),
		.subtract_flag(subtract_flag),
		.half_flag    (half_flag),
		.carry_flag   (carry_flag),
		.cycle_count  (cycle_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic [7:0] cb_op(logic [1:0] grp, logic [2:0] sel, logic [2:0] idx);
		return {grp, sel, idx};
	endfunction

	// executes one item against the shadow state, returns the result item
	function automatic res_t execute_item(item_t it);
		res_t       r;
		logic [2:0] idx;
		logic [2:0] sel;
		logic [1:0] grp;
		logic [7:0] v;
		logic [7:0] mask;
		logic [7:0] nv;
		logic       co;
		logic       cin;
		logic       is_mem;
		r = '0;
		r.addr = {shadow_regs[rsb_pkg::REG_H], shadow_regs[rsb_pkg::REG_L]};
		case (it.mode)
		rsb_pkg::MODE_EXEC: begin
			idx = it.opcode[2:0];
			sel = it.opcode[5:3];
			grp = it.opcode[7:6];
			is_mem = (idx == rsb_pkg::MEM_INDEX);
			v = is_mem ? it.operand : shadow_regs[idx];
			mask = 8'h01 << sel;
			cin = shadow_flags[0];
			case (grp)
			rsb_pkg::GRP_SHIFT: begin
				case (sel)
				rsb_pkg::SH_RLC: begin co = v[7]; nv = {v[6:0], v[7]}; end
				rsb_pkg::SH_RRC: begin co = v[0]; nv = {v[0], v[7:1]}; end
				rsb_pkg::SH_RL: begin co = v[7]; nv = {v[6:0], cin}; end
				rsb_pkg::SH_RR: begin co = v[0]; nv = {cin, v[7:1]}; end
				rsb_pkg::SH_SLA: begin co = v[7]; nv = {v[6:0], 1'b0}; end
				rsb_pkg::SH_SRA: begin co = v[0]; nv = {v[7], v[7:1]}; end
				rsb_pkg::SH_SWAP: begin co = 1'b0; nv = {v[3:0], v[7:4]}; end
				default: begin co = v[0]; nv = {1'b0, v[7:1]}; end
				endcase
				shadow_flags = {nv == 8'h00, 1'b0, 1'b0, co};
			end
			rsb_pkg::GRP_BIT: begin
				nv = v;
				shadow_flags = {(v & mask) == 8'h00, 1'b0, 1'b1, shadow_flags[0]};
			end
			rsb_pkg::GRP_RES: nv = v & ~mask;
			default: nv = v | mask;
			endcase
			if (grp != rsb_pkg::GRP_BIT) begin
				if (is_mem)
					r.mw = 1'b1;
				else
					shadow_regs[idx] = nv;
			end
			r.value = nv;
			if (!is_mem)
				r.cycles = rsb_pkg::CYC_REG;
			else
				r.cycles = (grp == rsb_pkg::GRP_BIT) ? rsb_pkg::CYC_BIT_MEM : rsb_pkg::CYC_MEM;
		end
		rsb_pkg::MODE_LOAD_REG: begin
			r.value = it.operand;
			if (it.tgt != rsb_pkg::MEM_INDEX)
				shadow_regs[it.tgt] = it.operand;
		end
		rsb_pkg::MODE_LOAD_FLAGS: begin
			shadow_flags = it.operand[7:4];
			r.value = {it.operand[7:4], 4'h0};
		end
		default: ;
		endcase
		{r.z, r.n, r.h, r.c} = shadow_flags;
		return r;
	endfunction

	function automatic void plan(logic [1:0] m, logic [7:0] op, logic [2:0] t, logic [7:0] d);
		row_t row;
		row.stim = {m, op, t, d};
		row.known = 1'b0;
		row.want = '0;
		directed.push_back(row);
	endfunction

	function automatic void plan_known(logic [1:0] m, logic [7:0] op, logic [2:0] t,
			logic [7:0] d, logic [7:0] v, logic mw, logic [15:0] a, logic [3:0] znhc,
			logic [4:0] cyc);
		row_t row;
		row.stim = {m, op, t, d};
		row.known = 1'b1;
		row.want = {v, mw, a, znhc, cyc};
		directed.push_back(row);
	endfunction

	function automatic item_t random_item();
		item_t it;
		int    pick;
		pick = $urandom_range(0, 99);
		it.opcode = 8'($urandom_range(0, 255));
		it.tgt = 3'($urandom_range(0, 7));
		it.operand = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0)
			it.operand = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		if (pick < 70)
			it.mode = rsb_pkg::MODE_EXEC;
		else if (pick < 88)
			it.mode = rsb_pkg::MODE_LOAD_REG;
		else if (pick < 97)
			it.mode = rsb_pkg::MODE_LOAD_FLAGS;
		else
			it.mode = MODE_UNUSED;
		return it;
	endfunction

	// drives one item and returns at the edge where it is accepted
	task automatic send_item(input item_t it, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.mode;
		opcode <= it.opcode;
		target_reg <= it.tgt;
		operand_byte <= it.operand;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want != got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result();
		res_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: result item with none expected, expected none actual %0h",
				$time, result_byte);
			mismatches++;
		end else begin
			want = pending_results.pop_front();
			check_field("result_byte", 16'(want.value), 16'(result_byte));
			check_field("mem_write", 16'(want.mw), 16'(mem_write));
			check_field("mem_addr", want.addr, mem_addr);
			check_field("zero_flag", 16'(want.z), 16'(zero_flag));
			check_field("subtract_flag", 16'(want.n), 16'(subtract_flag));
			check_field("half_flag", 16'(want.h), 16'(half_flag));
			check_field("carry_flag", 16'(want.c), 16'(carry_flag));
			check_field("cycle_count", 16'(want.cycles), 16'(cycle_count));
		end
	endtask

	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				check_result();
				stall_left = recv_idle ? $urandom_range(0, 4) : 0;
			end
			if (hold_req) begin
				stall_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	initial begin : sender
		res_t  want;
		item_t it;
		mismatches = 0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		hold_req = 1'b0;
		foreach (shadow_regs[i])
			shadow_regs[i] = 8'h00;
		shadow_flags = 4'h0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= rsb_pkg::MODE_EXEC;
		opcode <= 8'h00;
		target_reg <= 3'd0;
		operand_byte <= 8'h00;

		plan_known(MODE_UNUSED, 8'hFF, 3'd7, 8'hFF, 8'h00, 1'b0, 16'h0000, 4'b0000,
			rsb_pkg::CYC_NONE);
		plan_known(rsb_pkg::MODE_LOAD_FLAGS, 8'h00, 3'd0, 8'hFF, 8'hF0, 1'b0, 16'h0000,
			4'b1111, rsb_pkg::CYC_NONE);
		plan_known(rsb_pkg::MODE_LOAD_REG, 8'h00, rsb_pkg::REG_H, 8'hFF, 8'hFF, 1'b0,
			16'h0000, 4'b1111, rsb_pkg::CYC_NONE);
		plan_known(rsb_pkg::MODE_LOAD_REG, 8'h00, rsb_pkg::REG_L, 8'hFF, 8'hFF, 1'b0,
			16'hFF00, 4'b1111, rsb_pkg::CYC_NONE);
		plan_known(rsb_pkg::MODE_LOAD_REG, 8'h00, rsb_pkg::MEM_INDEX, 8'h5A, 8'h5A, 1'b0,
			16'hFFFF, 4'b1111, rsb_pkg::CYC_NONE);
		plan_known(rsb_pkg::MODE_LOAD_REG, 8'h00, REG_A, 8'h80, 8'h80, 1'b0,
			16'hFFFF, 4'b1111, rsb_pkg::CYC_NONE);
		plan_known(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_SHIFT, rsb_pkg::SH_RLC, REG_A),
			3'd0, 8'h00, 8'h01, 1'b0, 16'hFFFF, 4'b0001, rsb_pkg::CYC_REG);
		plan_known(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_SHIFT, rsb_pkg::SH_SWAP, REG_B),
			3'd0, 8'h00, 8'h00, 1'b0, 16'hFFFF, 4'b1000, rsb_pkg::CYC_REG);
		plan_known(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_BIT, 3'd7, rsb_pkg::MEM_INDEX),
			3'd0, 8'h80, 8'h80, 1'b0, 16'hFFFF, 4'b0010, rsb_pkg::CYC_BIT_MEM);
		plan_known(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_SET, 3'd0, rsb_pkg::MEM_INDEX),
			3'd0, 8'h00, 8'h01, 1'b1, 16'hFFFF, 4'b0010, rsb_pkg::CYC_MEM);
		plan_known(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_RES, 3'd7, rsb_pkg::MEM_INDEX),
			3'd0, 8'hFF, 8'h7F, 1'b1, 16'hFFFF, 4'b0010, rsb_pkg::CYC_MEM);
		plan_known(rsb_pkg::MODE_LOAD_FLAGS, 8'h00, 3'd0, 8'h10, 8'h10, 1'b0, 16'hFFFF,
			4'b0001, rsb_pkg::CYC_NONE);
		plan_known(rsb_pkg::MODE_LOAD_REG, 8'h00, rsb_pkg::REG_H, 8'h00, 8'h00, 1'b0,
			16'hFFFF, 4'b0001, rsb_pkg::CYC_NONE);
		plan_known(rsb_pkg::MODE_LOAD_REG, 8'h00, rsb_pkg::REG_L, 8'h00, 8'h00, 1'b0,
			16'h00FF, 4'b0001, rsb_pkg::CYC_NONE);
		plan(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_SHIFT, rsb_pkg::SH_RL, REG_B), 3'd0,
			8'h00);
		plan(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_SHIFT, rsb_pkg::SH_RR,
			rsb_pkg::MEM_INDEX), 3'd0, 8'h01);
		plan(rsb_pkg::MODE_LOAD_REG, 8'h00, REG_C, 8'hC3);
		plan(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_SHIFT, rsb_pkg::SH_SLA, REG_C), 3'd0,
			8'h00);
		plan(rsb_pkg::MODE_LOAD_REG, 8'h00, REG_D, 8'h81);
		plan(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_SHIFT, rsb_pkg::SH_SRA, REG_D), 3'd0,
			8'h00);
		plan(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_SHIFT, rsb_pkg::SH_SRL, REG_E), 3'd0,
			8'h00);
		plan(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_SHIFT, rsb_pkg::SH_RRC,
			rsb_pkg::REG_H), 3'd0, 8'h00);
		plan(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_SHIFT, rsb_pkg::SH_RLC,
			rsb_pkg::REG_L), 3'd0, 8'h00);
		plan(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_BIT, 3'd0, REG_B), 3'd0, 8'h00);
		plan(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_RES, 3'd3, REG_A), 3'd0, 8'h00);
		plan(rsb_pkg::MODE_EXEC, cb_op(rsb_pkg::GRP_SET, 3'd7, REG_C), 3'd0, 8'h00);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_item(directed[i].stim, $urandom_range(0, 4));
			want = execute_item(directed[i].stim);
			pending_results.push_back(directed[i].known ? directed[i].want : want);
		end

		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			send_idle = (blk % 4 == 0) || (blk % 4 == 2);
			recv_idle = (blk % 4 == 0) || (blk % 4 == 3);
			if (blk == RANDOM_BLOCKS / 2) begin
				// drain, then hold the output long enough to back up the input
				in_valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
				hold_req = 1'b1;
				for (int k = 0; k < 24; k++) begin
					it = random_item();
					send_item(it, 0);
					pending_results.push_back(execute_item(it));
				end
			end
			for (int k = 0; k < BLOCK_ITEMS; k++) begin
				it = random_item();
				send_item(it, send_idle ? $urandom_range(0, 4) : 0);
				pending_results.push_back(execute_item(it));
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
